[rtl/core/pcm_gain_limiter_meter_macros.svh]
// assertion macros for the pcm gain limiter meter
`ifndef PCM_GAIN_LIMITER_METER_MACROS_SVH
`define PCM_GAIN_LIMITER_METER_MACROS_SVH

`ifndef SYNTH
`define PGLM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pglm assertion failed");
`define PGLM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pglm assertion failed");
`else
`define PGLM_ASSERT_IMP(lbl, ante, cons)
`define PGLM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/pgl_pkg.sv]
// shared types and constants for the pcm gain limiter meter
package pgl_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int GAIN_W     = 24;
	localparam int MAG_W      = SAMPLE_W + GAIN_W;
	localparam int PEAK_W     = 40;
	localparam int TOTAL_W    = 48;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int FMT_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMITER = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 4'd3;

	localparam logic [FMT_W-1:0] FMT_16 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_24 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_32 = 2'd2;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h010000;
	localparam logic [PEAK_W-1:0] PEAK_MAX   = '1;

	typedef struct packed {
		logic              active;
		logic              limiter_enable;
		logic [FMT_W-1:0]  sample_format;
		logic [GAIN_W-1:0] linear_gain;
	} cfg_t;

	typedef struct packed {
		logic                clear;
		logic                bypass;
		logic                neg;
		logic [FMT_W-1:0]    fmt;
		logic [SAMPLE_W-1:0] raw;
		logic [MAG_W-1:0]    mag;
	} prod_item_t;

endpackage

[rtl/core/pgl_cfg_regs.sv]
// configuration register file
module pgl_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pgl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pgl_pkg::CFG_DATA_W-1:0] cfg_data,
	output pgl_pkg::cfg_t                  cfg
);
	import pgl_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active         <= 1'b0;
			cfg_q.limiter_enable <= 1'b0;
			cfg_q.sample_format  <= FMT_16;
			cfg_q.linear_gain    <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ACTIVE:  cfg_q.active         <= cfg_data[0];
				REG_LIMITER: cfg_q.limiter_enable <= cfg_data[0];
				REG_FORMAT:  cfg_q.sample_format  <= cfg_data[FMT_W-1:0];
				REG_GAIN:    cfg_q.linear_gain    <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/pgl_gain_mult.sv]
// input register, sign extension, magnitude and gain multiply
module pgl_gain_mult (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pgl_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [pgl_pkg::SAMPLE_W-1:0] sample_in,
	output logic                         s2_valid,
	input  logic                         s2_ready,
	output pgl_pkg::prod_item_t          s2_item
);
	import pgl_pkg::*;

	logic                v_s1;
	logic                kind_s1;
	logic [SAMPLE_W-1:0] raw_s1;
	logic                v_s2;
	prod_item_t          item_s2;
	logic                ld2_ok;
	logic [SAMPLE_W-1:0] ext;
	logic [SAMPLE_W-1:0] abs_mag;
	logic                neg;
	prod_item_t          item_d;

	assign ld2_ok   = !v_s2 || s2_ready;
	assign in_ready = !v_s1 || ld2_ok;
	assign s2_valid = v_s2;
	assign s2_item  = item_s2;

	always_comb begin
		unique case (cfg.sample_format)
			FMT_16:  ext = {{16{raw_s1[15]}}, raw_s1[15:0]};
			FMT_24:  ext = {{8{raw_s1[23]}}, raw_s1[23:0]};
			default: ext = raw_s1;
		endcase
		neg     = ext[SAMPLE_W-1];
		abs_mag = neg ? (~ext + 1'b1) : ext;
	end

	always_comb begin
		item_d.clear  = (kind_s1 == KIND_CLEAR);
		item_d.bypass = !cfg.active || (cfg.sample_format != FMT_16 &&
			cfg.sample_format != FMT_24 && cfg.sample_format != FMT_32);
		item_d.neg    = neg;
		item_d.fmt    = cfg.sample_format;
		item_d.raw    = raw_s1;
		item_d.mag    = abs_mag * cfg.linear_gain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (ld2_ok) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			raw_s1  <= sample_in;
		end
		if (v_s1 && ld2_ok) begin
			item_s2 <= item_d;
		end
	end

endmodule

[rtl/core/pgl_stats.sv]
// limiter, saturation, level meter, counters and result register
module pgl_stats #(
	parameter int GAIN_FRAC_BITS = 16,
	parameter int COUNT_WIDTH    = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pgl_pkg::cfg_t                cfg,
	input  logic                         s2_valid,
	output logic                         s2_ready,
	input  pgl_pkg::prod_item_t          s2_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pgl_pkg::SAMPLE_W-1:0] sample_out,
	output logic                         clipped,
	output logic [pgl_pkg::PEAK_W-1:0]   peak_out,
	output logic [pgl_pkg::TOTAL_W-1:0]  clip_total,
	output logic [pgl_pkg::TOTAL_W-1:0]  sample_total
);
	import pgl_pkg::*;

	`include "pcm_gain_limiter_meter_macros.svh"

	localparam int WIDE_W = MAG_W + 16;

	logic                   out_valid_q;
	logic [SAMPLE_W-1:0]    sample_q;
	logic                   clipped_q;
	logic [PEAK_W-1:0]      peak_q;
	logic [COUNT_WIDTH-1:0] clip_cnt_q;
	logic [COUNT_WIDTH-1:0] proc_cnt_q;

	logic                   fire;
	logic [MAG_W-1:0]       fs;
	logic [WIDE_W-1:0]      wide;
	logic [WIDE_W-1:0]      cand_full;
	logic [PEAK_W-1:0]      cand;
	logic [MAG_W-1:0]       gmag;
	logic [MAG_W-1:0]       lim;
	logic [MAG_W-1:0]       sat;
	logic                   clip;
	logic [SAMPLE_W-1:0]    res;
	logic [SAMPLE_W-1:0]    sample_n;
	logic                   clipped_n;
	logic [PEAK_W-1:0]      peak_n;
	logic [COUNT_WIDTH-1:0] clip_cnt_n;
	logic [COUNT_WIDTH-1:0] proc_cnt_n;

	assign s2_ready = !out_valid_q || out_ready;
	assign fire     = s2_valid && s2_ready;

	always_comb begin
		unique case (s2_item.fmt)
			FMT_16: begin
				fs   = MAG_W'(1) << 15;
				wide = WIDE_W'(s2_item.mag) << 16;
			end
			FMT_24: begin
				fs   = MAG_W'(1) << 23;
				wide = WIDE_W'(s2_item.mag) << 8;
			end
			default: begin
				fs   = MAG_W'(1) << 31;
				wide = WIDE_W'(s2_item.mag);
			end
		endcase
		cand_full = wide >> GAIN_FRAC_BITS;
		cand      = (|cand_full[WIDE_W-1:PEAK_W]) ? PEAK_MAX : cand_full[PEAK_W-1:0];
		gmag      = s2_item.mag >> GAIN_FRAC_BITS;
		lim       = (cfg.limiter_enable && gmag > fs) ? fs : gmag;
		if (s2_item.neg) begin
			clip = lim > fs;
			sat  = clip ? fs : lim;
			res  = SAMPLE_W'(~sat + 1'b1);
		end else begin
			clip = lim > (fs - 1'b1);
			sat  = clip ? (fs - 1'b1) : lim;
			res  = sat[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		sample_n   = res;
		clipped_n  = clip;
		peak_n     = (cand > peak_q) ? cand : peak_q;
		clip_cnt_n = clip ? clip_cnt_q + 1'b1 : clip_cnt_q;
		proc_cnt_n = proc_cnt_q + 1'b1;
		priority if (s2_item.clear) begin
			sample_n   = '0;
			clipped_n  = 1'b0;
			peak_n     = '0;
			clip_cnt_n = '0;
			proc_cnt_n = '0;
		end else if (s2_item.bypass) begin
			sample_n   = s2_item.raw;
			clipped_n  = 1'b0;
			peak_n     = peak_q;
			clip_cnt_n = clip_cnt_q;
			proc_cnt_n = proc_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			peak_q      <= '0;
			clip_cnt_q  <= '0;
			proc_cnt_q  <= '0;
		end else begin
			if (s2_ready) begin
				out_valid_q <= s2_valid;
			end
			if (fire) begin
				peak_q     <= peak_n;
				clip_cnt_q <= clip_cnt_n;
				proc_cnt_q <= proc_cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_q  <= sample_n;
			clipped_q <= clipped_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_q;
	assign clipped      = clipped_q;
	assign peak_out     = peak_q;
	assign clip_total   = TOTAL_W'(clip_cnt_q);
	assign sample_total = TOTAL_W'(proc_cnt_q);

	`PGLM_ASSERT_NXT(a_clear_zeroes, fire && s2_item.clear, !(|{peak_q, clip_cnt_q, proc_cnt_q}))
	`PGLM_ASSERT_NXT(a_peak_monotonic, fire && !s2_item.clear, peak_q >= $past(peak_q))
	`PGLM_ASSERT_NXT(a_count_holds, !fire, $stable(proc_cnt_q) && $stable(clip_cnt_q))
	`PGLM_ASSERT_NXT(a_clip_step, fire && !s2_item.clear, clip_cnt_q - $past(clip_cnt_q) <= 1'b1)
	`PGLM_ASSERT_IMP(a_bypass_no_clip, fire && (s2_item.bypass || s2_item.clear), !clipped_n)

endmodule

[rtl/core/pcm_gain_limiter_meter.sv]
// pcm gain limiter meter: gain stage with hard limiter and level meter
// accepted items move through the input, product and result registers in order
// one item per cycle unless stalled; 32x24 gain multiply sits before the product register
// stalls hold each stage in place; up to two items are taken while a result waits
// reset: asynchronous, active low; clears statistics and loads register defaults
// (active 0, limiter 0, 16-bit format, unity gain)
module pcm_gain_limiter_meter #(
	parameter int GAIN_FRAC_BITS = 16,
	parameter int COUNT_WIDTH    = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pgl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pgl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic signed [pgl_pkg::SAMPLE_W-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [pgl_pkg::SAMPLE_W-1:0] sample_out,
	output logic                           clipped,
	output logic [pgl_pkg::PEAK_W-1:0]     peak_out,
	output logic [pgl_pkg::TOTAL_W-1:0]    clip_total,
	output logic [pgl_pkg::TOTAL_W-1:0]    sample_total
);
	import pgl_pkg::*;

	cfg_t                cfg;
	logic                s2_valid;
	logic                s2_ready;
	prod_item_t          s2_item;
	logic [SAMPLE_W-1:0] sample_res;

	pgl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pgl_gain_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.sample_in (sample_in),
		.s2_valid  (s2_valid),
		.s2_ready  (s2_ready),
		.s2_item   (s2_item)
	);

	pgl_stats #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.s2_valid     (s2_valid),
		.s2_ready     (s2_ready),
		.s2_item      (s2_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_res),
		.clipped      (clipped),
		.peak_out     (peak_out),
		.clip_total   (clip_total),
		.sample_total (sample_total)
	);

	assign sample_out = $signed(sample_res);

endmodule
